### design/dqdc_pkg.sv
// ----------------------------------------------------------------------------
// dqdc_pkg
// shared types, constants and step tables of the detent counter
// ----------------------------------------------------------------------------
package dqdc_pkg;

    localparam int DQDC_COUNT_WIDTH = 16;
    localparam int DEBOUNCE_W       = 16;
    localparam int ROT_W            = 16;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd48000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_SAT   = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM_MODE  = 4'd1;

    localparam logic [1:0] CODE_DETENT = 2'b00;

    localparam logic signed [ROT_W-1:0] ROT_MAX     = 16'sh7FFF;
    localparam logic signed [ROT_W-1:0] ROT_MIN     = 16'sh8000;
    localparam logic signed [ROT_W-1:0] ROT_POS_ONE = 16'sh0001;
    localparam logic signed [ROT_W-1:0] ROT_NEG_ONE = 16'shFFFF;
    localparam logic signed [ROT_W-1:0] ROT_ZERO    = 16'sh0000;

    typedef enum logic {
        EV_CODE = 1'b0,
        EV_READ = 1'b1
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [1:0] code;
    } dqdc_event_t;

    function automatic logic [1:0] step_cw(input logic [1:0] code);
        logic [1:0] r;
        case (code)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd3;
            2'd3:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] step_ccw(input logic [1:0] code);
        logic [1:0] r;
        case (code)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd0;
            2'd3:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### design/debounced_quadrature_detent_counter.sv
// ----------------------------------------------------------------------------
// debounced_quadrature_detent_counter
// Takes one word per clock, a pin sample tick or a read request. The front
// debounces the pins and queues code and read events in a four-entry queue;
// the back decodes detents and answers reads from an output register. A read
// event waits in the queue until the back pops it and loads the output register
// and m_valid, which it does only once no earlier result is left waiting.
// s_ready stays high while the queue has room, so words flow at one per clock
// unless results sit untaken long enough to fill the queue.
// ----------------------------------------------------------------------------
module debounced_quadrature_detent_counter #(
    parameter int COUNT_WIDTH = dqdc_pkg::DQDC_COUNT_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic                                s_pin_a,
    input  logic                                s_pin_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dqdc_pkg::ROT_W-1:0]   m_rotation,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dqdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dqdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dqdc_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_ticks_reg;
    logic                  momentum_mode_reg;
    logic                  queue_full;
    logic                  ev_push;
    dqdc_event_t           ev_in;
    logic                  ev_valid;
    logic                  ev_pop;
    dqdc_event_t           ev_out;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            momentum_mode_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[DEBOUNCE_W-1:0];
                REG_MOMENTUM_MODE:  momentum_mode_reg  <= cfg_data[0];
                default: begin
                    debounce_ticks_reg <= debounce_ticks_reg;
                end
            endcase
        end
    end

    dqdc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_pin_a        (s_pin_a),
        .s_pin_b        (s_pin_b),
        .debounce_ticks (debounce_ticks_reg),
        .queue_full     (queue_full),
        .ev_push        (ev_push),
        .ev_data        (ev_in)
    );

    dqdc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_push),
        .push_data (ev_in),
        .full      (queue_full),
        .pop       (ev_pop),
        .not_empty (ev_valid),
        .pop_data  (ev_out)
    );

    dqdc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .momentum_mode (momentum_mode_reg),
        .ev_valid      (ev_valid),
        .ev_data       (ev_out),
        .ev_pop        (ev_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rotation    (m_rotation)
    );

endmodule

### design/dqdc_front.sv
// ----------------------------------------------------------------------------
// dqdc_front
// pin debounce; turns accepted words into code and read events
// ----------------------------------------------------------------------------
module dqdc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic                              s_pin_a,
    input  logic                              s_pin_b,
    input  logic [dqdc_pkg::DEBOUNCE_W-1:0]   debounce_ticks,
    input  logic                              queue_full,
    output logic                              ev_push,
    output dqdc_pkg::dqdc_event_t             ev_data
);
    import dqdc_pkg::*;

    logic [1:0]            prev_pins_reg, prev_pins_next;
    logic [DEBOUNCE_W-1:0] count_reg, count_next;
    logic                  armed_reg, armed_next;
    logic [1:0]            code;
    logic [DEBOUNCE_W-1:0] count_inc;
    logic                  take;

    assign s_ready   = !queue_full;
    assign take      = s_valid && s_ready;
    assign code      = {s_pin_b, s_pin_a};
    assign count_inc = (count_reg == DEBOUNCE_SAT) ? count_reg : count_reg + 1'b1;

    always_comb begin
        prev_pins_next = prev_pins_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        ev_push        = 1'b0;
        ev_data.kind   = EV_CODE;
        ev_data.code   = code;
        if (take) begin
            if (s_cmd) begin
                ev_push      = 1'b1;
                ev_data.kind = EV_READ;
            end else if (code != prev_pins_reg) begin
                prev_pins_next = code;
                count_next     = '0;
                armed_next     = 1'b1;
            end else if (armed_reg) begin
                count_next = count_inc;
                if (count_inc >= debounce_ticks) begin
                    ev_push    = 1'b1;
                    armed_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pins_reg <= '0;
            count_reg     <= '0;
            armed_reg     <= 1'b1;
        end else begin
            prev_pins_reg <= prev_pins_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

### design/dqdc_queue.sv
// ----------------------------------------------------------------------------
// dqdc_queue
// short event queue between the debounce front and the counter back
// ----------------------------------------------------------------------------
module dqdc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  dqdc_pkg::dqdc_event_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output dqdc_pkg::dqdc_event_t pop_data
);
    import dqdc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    dqdc_event_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue fill beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("pop from empty queue");

    a_fill_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill lost a word");

endmodule

### design/dqdc_back.sv
// ----------------------------------------------------------------------------
// dqdc_back
// detent decoding, saturating count and read result register
// ----------------------------------------------------------------------------
module dqdc_back #(
    parameter int COUNT_WIDTH = dqdc_pkg::DQDC_COUNT_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                momentum_mode,
    input  logic                                ev_valid,
    input  dqdc_pkg::dqdc_event_t               ev_data,
    output logic                                ev_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dqdc_pkg::ROT_W-1:0]   m_rotation
);
    import dqdc_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > ROT_W) ? COUNT_WIDTH : ROT_W;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic signed [EXT_W-1:0]       CLAMP_HI = EXT_W'(ROT_MAX);
    localparam logic signed [EXT_W-1:0]       CLAMP_LO = EXT_W'(ROT_MIN);

    logic signed [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]                    stable_reg, stable_next;
    logic                          primed_reg, primed_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [ROT_W-1:0]       m_rotation_reg, m_rotation_next;
    logic signed [EXT_W-1:0]       count_ext;
    logic                          out_free;

    assign out_free   = !m_valid_reg || m_ready;
    assign ev_pop     = ev_valid && ((ev_data.kind == EV_CODE) || out_free);
    assign count_ext  = EXT_W'(count_reg);
    assign m_valid    = m_valid_reg;
    assign m_rotation = m_rotation_reg;

    always_comb begin
        count_next      = count_reg;
        stable_next     = stable_reg;
        primed_next     = primed_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_rotation_next = m_rotation_reg;
        if (ev_pop) begin
            case (ev_data.kind)
                EV_CODE: begin
                    if (!primed_reg) begin
                        stable_next = ev_data.code;
                        primed_next = 1'b1;
                    end else if (ev_data.code != stable_reg) begin
                        if (ev_data.code == step_cw(stable_reg)) begin
                            if (ev_data.code == CODE_DETENT && count_reg != CNT_MAX) begin
                                count_next = count_reg + CNT_ONE;
                            end
                        end else if (ev_data.code == step_ccw(stable_reg)) begin
                            if (ev_data.code == CODE_DETENT && count_reg != CNT_MIN) begin
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        stable_next = ev_data.code;
                    end
                end
                EV_READ: begin
                    m_valid_next = 1'b1;
                    if (momentum_mode) begin
                        if (count_reg > 0) begin
                            m_rotation_next = ROT_POS_ONE;
                            count_next      = count_reg - CNT_ONE;
                        end else if (count_reg < 0) begin
                            m_rotation_next = ROT_NEG_ONE;
                            count_next      = count_reg + CNT_ONE;
                        end else begin
                            m_rotation_next = ROT_ZERO;
                        end
                    end else begin
                        if (count_ext > CLAMP_HI) begin
                            m_rotation_next = ROT_MAX;
                        end else if (count_ext < CLAMP_LO) begin
                            m_rotation_next = ROT_MIN;
                        end else begin
                            m_rotation_next = count_ext[ROT_W-1:0];
                        end
                        count_next = '0;
                    end
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        m_rotation_reg <= m_rotation_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            stable_reg  <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            stable_reg  <= stable_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### tb/sv/detent_count_checker.sv
// ----------------------------------------------------------------------------
// detent_count_checker
// Watches the tick, read, result and register channels of the detent counter.
// It keeps its own debounce and detent state, works out the rotation that
// each accepted read should return, and compares it with the next result
// word. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module detent_count_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_cmd,
    input  logic                                s_pin_a,
    input  logic                                s_pin_b,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [dqdc_pkg::ROT_W-1:0]   m_rotation,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [dqdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dqdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  rotations_owed
);
    import dqdc_pkg::*;

    // next code one step clockwise / counter-clockwise, two bits per code
    localparam logic [7:0] CW_NEXT  = {2'd1, 2'd3, 2'd0, 2'd2};
    localparam logic [7:0] CCW_NEXT = {2'd2, 2'd0, 2'd3, 2'd1};

    logic [DEBOUNCE_W-1:0]       settle_limit;
    logic                        momentum;
    logic [1:0]                  last_pins;
    logic [DEBOUNCE_W-1:0]       hold_cnt;
    logic                        hold_armed;
    logic [1:0]                  settled_code;
    logic                        settled_valid;
    logic signed [ROT_W-1:0]     detents;
    logic signed [ROT_W-1:0]     rotation_due[$];

    initial begin
        mismatches     = 0;
        rotations_owed = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic take_code(input logic [1:0] code);
        if (!settled_valid) begin
            settled_code  = code;
            settled_valid = 1'b1;
        end else if (code != settled_code) begin
            if (code == CW_NEXT[{settled_code, 1'b0} +: 2]) begin
                if (code == CODE_DETENT && detents != ROT_MAX)
                    detents = detents + ROT_POS_ONE;
            end else if (code == CCW_NEXT[{settled_code, 1'b0} +: 2]) begin
                if (code == CODE_DETENT && detents != ROT_MIN)
                    detents = detents - ROT_POS_ONE;
            end
            settled_code = code;
        end
    endtask

    task automatic advance_pins(input logic [1:0] code);
        if (code != last_pins) begin
            last_pins  = code;
            hold_cnt   = '0;
            hold_armed = 1'b1;
        end else if (hold_armed) begin
            if (hold_cnt != DEBOUNCE_SAT)
                hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt >= settle_limit) begin
                take_code(code);
                hold_armed = 1'b0;
            end
        end
    endtask

    task automatic answer_read();
        logic signed [ROT_W-1:0] val;
        if (momentum) begin
            if (detents > ROT_ZERO)
                val = ROT_POS_ONE;
            else if (detents < ROT_ZERO)
                val = ROT_NEG_ONE;
            else
                val = ROT_ZERO;
            detents = detents - val;
        end else begin
            val     = detents;
            detents = ROT_ZERO;
        end
        rotation_due.push_back(val);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settle_limit  = DEBOUNCE_RESET;
            momentum      = 1'b0;
            last_pins     = 2'b00;
            hold_cnt      = '0;
            hold_armed    = 1'b1;
            settled_code  = 2'b00;
            settled_valid = 1'b0;
            detents       = ROT_ZERO;
            rotation_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS: settle_limit = cfg_data;
                    REG_MOMENTUM_MODE:  momentum = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (rotation_due.size() == 0)
                    report_mismatch($sformatf("rotation %0d with no read waiting", m_rotation));
                else if (m_rotation !== rotation_due[0])
                    report_mismatch($sformatf("rotation %0d, expected %0d",
                                              m_rotation, rotation_due.pop_front()));
                else
                    void'(rotation_due.pop_front());
            end
            if (s_valid && s_ready) begin
                if (ev_kind_t'(s_cmd) == EV_READ)
                    answer_read();
                else
                    advance_pins({s_pin_b, s_pin_a});
            end
        end
        rotations_owed = rotation_due.size();
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the debounced quadrature detent counter. A short
// directed run covers first capture, clockwise and counter-clockwise detents,
// illegal jumps, bounce and a zero debounce limit; then random encoder walks
// with reads under several register settings, with random gaps and result
// stalls.
// ----------------------------------------------------------------------------
module tb;
    import dqdc_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [7:0] CW_WALK  = {2'd1, 2'd3, 2'd0, 2'd2};
    localparam logic [7:0] CCW_WALK = {2'd2, 2'd0, 2'd3, 2'd1};

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_cmd;
    logic                       s_pin_a;
    logic                       s_pin_b;
    logic                       m_valid;
    logic                       m_ready = 1'b1;
    logic signed [ROT_W-1:0]    m_rotation;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int                         mismatches;
    int                         rotations_owed;
    int                         cycles = 0;
    int                         ready_run = 0;
    bit                         idle_on;
    bit                         stall_on;
    logic [1:0]                 walk_code;

    debounced_quadrature_detent_counter i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_pin_a    (s_pin_a),
        .s_pin_b    (s_pin_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rotation (m_rotation),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    detent_count_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_pin_a        (s_pin_a),
        .s_pin_b        (s_pin_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rotation     (m_rotation),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .rotations_owed (rotations_owed)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("debounced_quadrature_detent_counter: mismatch");
            $finish;
        end
    end

    // result side: random runs of ready and stall
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_run = $urandom_range(0, 15);
            m_ready   = !stall_on || ($urandom_range(0, 2) != 0);
        end else begin
            ready_run--;
        end
    end

    task automatic put_word(input ev_kind_t cmd, input logic [1:0] code);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_cmd   = cmd;
        s_pin_a = code[0];
        s_pin_b = code[1];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_pins(input logic [1:0] code, input int ticks);
        repeat (ticks) put_word(EV_CODE, code);
    endtask

    task automatic drain_rotations();
        @(negedge aclk);
        s_valid = 1'b0;
        while (rotations_owed != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_rotations();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_walk(input int words, input int limit);
        int sent;
        int pick;
        int span;
        int pause_at;
        sent     = 0;
        pause_at = $urandom_range(words / 4, 3 * words / 4);
        while (sent < words) begin
            if (pause_at >= 0 && sent >= pause_at) begin
                drain_rotations();
                pause_at = -1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                put_word(EV_READ, 2'($urandom));
                sent++;
            end else begin
                if (pick < 50)
                    walk_code = CW_WALK[{walk_code, 1'b0} +: 2];
                else if (pick < 85)
                    walk_code = CCW_WALK[{walk_code, 1'b0} +: 2];
                else if (pick < 93)
                    walk_code = walk_code ^ 2'b11;
                else
                    walk_code = 2'($urandom);
                span = (pick < 93) ? $urandom_range(1, limit + 2) : 1;
                hold_pins(walk_code, span);
                sent += span;
            end
        end
    endtask

    initial begin
        int lim;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cmd     = 1'b0;
        s_pin_a   = 1'b0;
        s_pin_b   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        stall_on  = 1'b1;
        walk_code = 2'b00;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        put_word(EV_READ, 2'b11);
        write_reg(REG_DEBOUNCE_TICKS, 16'd0);
        write_reg(REG_MOMENTUM_MODE, 16'd0);
        hold_pins(2'b00, 2);
        hold_pins(2'b10, 2);
        hold_pins(2'b11, 2);
        hold_pins(2'b01, 2);
        hold_pins(2'b00, 2);
        put_word(EV_READ, 2'b00);
        hold_pins(2'b01, 2);
        hold_pins(2'b11, 2);
        hold_pins(2'b10, 2);
        hold_pins(2'b00, 2);
        hold_pins(2'b11, 2);
        hold_pins(2'b00, 2);
        put_word(EV_CODE, 2'b01);
        put_word(EV_CODE, 2'b00);
        put_word(EV_CODE, 2'b01);
        put_word(EV_READ, 2'b11);
        walk_code = 2'b00;

        for (int phase = 0; phase < 4; phase++) begin
            idle_on  = (phase == 0 || phase == 2);
            stall_on = (phase == 0 || phase == 1);
            lim = $urandom_range(1, 4);
            write_reg(REG_DEBOUNCE_TICKS, 16'(lim));
            write_reg(REG_MOMENTUM_MODE, 16'(phase % 2));
            random_walk(160, lim);
        end

        drain_rotations();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && rotations_owed == 0)
            $display("debounced_quadrature_detent_counter: match");
        else
            $display("debounced_quadrature_detent_counter: mismatch");
        $finish;
    end

endmodule
